// ===== sv/swrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swrr_pkg
// Shared types and constants of the sliding-window receive reorder core.
// ----------------------------------------------------------------------------
package swrr_pkg;

    localparam int SEQ_W                = 16;
    localparam int TAG_W                = 8;
    localparam int WIN_W                = 5;
    localparam int EV_W                 = 3;
    localparam int DEFAULT_WINDOW_DEPTH = 16;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd16;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_DROPPED   = 3'd0,
        EV_DUPLICATE = 3'd1,
        EV_BUFFERED  = 3'd2,
        EV_DELIVERED = 3'd3,
        EV_STARTED   = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_WINDOW,
        ST_OFFSET,
        ST_SLOT,
        ST_EMIT,
        ST_DELIVER,
        ST_WALK_READ
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic write;
    } store_ctrl_t;

    typedef struct packed {
        logic slot_hit;
        logic next_valid;
    } store_stat_t;

endpackage

`default_nettype wire

// ===== sv/sliding_window_receive_reorder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_receive_reorder_core
// Receive reorder buffer: window check, duplicate check, buffering and
// in-order release of buffered packets, the sequence arithmetic on one shared adder.
// ----------------------------------------------------------------------------
// Sequence: a start item goes straight to emit; a data item passes window limit,
//   window test and offset in successive steps on the shared 16-bit adder, then
//   a slot check if it is to be buffered, and ends in emit or in delivery.
// Flow: a new item is taken only while the core is idle; each buffered packet
//   released after an in-order arrival takes a tag memory read, then an emit.
// Reset: clears the last delivered sequence number, slot valid bits and window
//   (to 16); the tag memory is not cleared.
module sliding_window_receive_reorder_core #(
    parameter int WINDOW_DEPTH = swrr_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration: window_size
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [swrr_pkg::WIN_W-1:0] cfg_data,
    // input words
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,  // packet_number[15:0], packet_tag[23:16]
    input  wire logic                       s_tuser,  // kind
    // result words
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [23:0]                m_tdata,  // out_number[15:0], out_tag[23:16]
    output logic      [swrr_pkg::EV_W-1:0]  m_tuser,  // event_res
    output logic                            m_tlast
);
    import swrr_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam logic [SEQ_W-1:0] DEPTH16 = SEQ_W'(WINDOW_DEPTH);

    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [SEQ_W-1:0]  lio_reg, lio_next;      // last in order == last delivered
    logic [SEQ_W-1:0]  num_reg, num_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    event_t            ev_reg, ev_next;
    logic [SEQ_W-1:0]  sum_reg, sum_next;
    logic [IDX_W-1:0]  slot_k_reg, slot_k_next;

    logic              m_valid_reg, m_valid_next;
    event_t            out_ev_reg, out_ev_next;
    logic [SEQ_W-1:0]  out_num_reg, out_num_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic              out_last_reg, out_last_next;

    logic [SEQ_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_sub, alu_later;
    logic [SEQ_W-1:0]  win_eff;
    logic [IDX_W:0]    k_full;
    logic              out_free, in_accept, out_load;
    store_ctrl_t       ctrl;
    store_stat_t       stat;
    logic [TAG_W-1:0]  head_tag;

    swrr_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_res),
        .later  (alu_later)
    );

    swrr_store #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .slot_k   (slot_k_reg),
        .wr_tag   (tag_reg),
        .stat     (stat),
        .head_tag (head_tag)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_tag_reg, out_num_reg};
    assign m_tuser  = out_ev_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        win_eff = ({{(SEQ_W-WIN_W){1'b0}}, win_reg} > DEPTH16)
                ? DEPTH16 : {{(SEQ_W-WIN_W){1'b0}}, win_reg};
        k_full  = alu_res[IDX_W:0] - {{IDX_W{1'b0}}, 1'b1};

        // shared adder operands
        case (state_reg)
            ST_LIMIT: begin
                alu_a = lio_reg; alu_b = win_eff; alu_sub = 1'b0;
            end
            ST_WINDOW: begin
                alu_a = num_reg; alu_b = sum_reg; alu_sub = 1'b1;
            end
            ST_OFFSET: begin
                alu_a = num_reg; alu_b = lio_reg; alu_sub = 1'b1;
            end
            ST_WALK_READ: begin
                alu_a = lio_reg; alu_b = {{(SEQ_W-1){1'b0}}, 1'b1}; alu_sub = 1'b0;
            end
            default: begin
                alu_a = lio_reg; alu_b = '0; alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        win_next      = win_reg;
        lio_next      = lio_reg;
        num_next      = num_reg;
        tag_next      = tag_reg;
        ev_next       = ev_reg;
        sum_next      = sum_reg;
        slot_k_next   = slot_k_reg;
        out_load      = 1'b0;
        out_ev_next   = out_ev_reg;
        out_num_next  = out_num_reg;
        out_tag_next  = out_tag_reg;
        out_last_next = out_last_reg;
        ctrl          = '0;

        if (cfg_valid && cfg_ready) begin
            win_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    num_next = s_tdata[15:0];
                    tag_next = s_tdata[23:16];
                    if (s_tuser == KIND_START) begin
                        lio_next   = s_tdata[15:0];
                        ctrl.clear = 1'b1;
                        ev_next    = EV_STARTED;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_LIMIT;
                    end
                end
            end
            ST_LIMIT: begin
                sum_next   = alu_res;
                state_next = ST_WINDOW;
            end
            ST_WINDOW: begin
                if (alu_later) begin
                    ev_next    = EV_DROPPED;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET: begin
                if (!alu_later) begin
                    ev_next    = EV_DUPLICATE;
                    state_next = ST_EMIT;
                end else if (alu_res == {{(SEQ_W-1){1'b0}}, 1'b1}) begin
                    lio_next   = num_reg;
                    state_next = ST_DELIVER;
                end else if (alu_res > DEPTH16) begin
                    ev_next    = EV_DROPPED;
                    state_next = ST_EMIT;
                end else begin
                    slot_k_next = k_full[IDX_W-1:0];
                    state_next  = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (stat.slot_hit) begin
                    ev_next = EV_DUPLICATE;
                end else begin
                    ctrl.write = 1'b1;
                    ev_next    = EV_BUFFERED;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_ev_next   = ev_reg;
                    out_num_next  = num_reg;
                    out_tag_next  = tag_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DELIVER: begin
                // the arriving packet, then release while the next slot holds one
                if (out_free) begin
                    out_load      = 1'b1;
                    out_ev_next   = EV_DELIVERED;
                    out_num_next  = num_reg;
                    out_tag_next  = tag_reg;
                    out_last_next = !stat.next_valid;
                    ctrl.shift    = 1'b1;
                    state_next    = stat.next_valid ? ST_WALK_READ : ST_IDLE;
                end
            end
            ST_WALK_READ: begin
                // head tag is ready in this state; ST_DELIVER emits it once the output is free
                lio_next   = alu_res;
                num_next   = alu_res;
                tag_next   = head_tag;
                state_next = ST_DELIVER;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= WINDOW_RESET;
            lio_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            lio_reg     <= lio_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg      <= num_next;
        tag_reg      <= tag_next;
        ev_reg       <= ev_next;
        sum_reg      <= sum_next;
        slot_k_reg   <= slot_k_next;
        out_ev_reg   <= out_ev_next;
        out_num_reg  <= out_num_next;
        out_tag_reg  <= out_tag_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    a_start_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_START)
            |=> state_reg == ST_EMIT && ev_reg == EV_STARTED)
        else $error("start item did not go straight to emit");

    a_nonlast_is_delivery: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tuser == EV_DELIVERED)
        else $error("only a delivery run may have several words");

    a_slot0_never_written: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.write |-> slot_k_reg != '0)
        else $error("slot of the next expected packet written");

    a_walk_from_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK_READ |-> $past(state_reg) == ST_DELIVER)
        else $error("release walk entered outside a delivery");
`endif

endmodule

`default_nettype wire

// ===== sv/swrr_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swrr_alu
// Shared 16-bit add/subtract unit with the modulo-2^16 "later than" test.
// ----------------------------------------------------------------------------
module swrr_alu (
    input  wire logic [swrr_pkg::SEQ_W-1:0] op_a,
    input  wire logic [swrr_pkg::SEQ_W-1:0] op_b,
    input  wire logic                       sub,
    output logic      [swrr_pkg::SEQ_W-1:0] result,
    output logic                            later
);
    import swrr_pkg::*;

    logic [SEQ_W-1:0] b_in;

    always_comb begin
        b_in   = sub ? ~op_b : op_b;
        result = op_a + b_in + {{(SEQ_W-1){1'b0}}, sub};
        // a later than b when (a - b) mod 2^16 is in 1..32767
        later  = (result != '0) && !result[SEQ_W-1];
    end

endmodule

`default_nettype wire

// ===== sv/swrr_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swrr_store
// Out-of-order slot store: circular valid bits plus a tag memory. Slot k is
// at physical entry base + k; a shift retires slot 0 by advancing base.
// ----------------------------------------------------------------------------
module swrr_store #(
    parameter int WINDOW_DEPTH = swrr_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire swrr_pkg::store_ctrl_t             ctrl,
    input  wire logic [$clog2(WINDOW_DEPTH)-1:0]   slot_k,
    input  wire logic [swrr_pkg::TAG_W-1:0]        wr_tag,
    output swrr_pkg::store_stat_t                  stat,
    output logic      [swrr_pkg::TAG_W-1:0]        head_tag
);
    import swrr_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam logic [IDX_W:0] DEPTH_W = (IDX_W+1)'(WINDOW_DEPTH);

    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]        base_reg, base_next;
    logic [IDX_W-1:0]        phys_k, base_inc;
    logic [IDX_W:0]          sum_k, sum_inc;
    logic [TAG_W-1:0]        tag_mem [WINDOW_DEPTH];
    logic [TAG_W-1:0]        head_tag_reg;

    always_comb begin
        sum_k    = {1'b0, base_reg} + {1'b0, slot_k};
        sum_inc  = {1'b0, base_reg} + {{IDX_W{1'b0}}, 1'b1};
        phys_k   = (sum_k >= DEPTH_W) ? IDX_W'(sum_k - DEPTH_W) : sum_k[IDX_W-1:0];
        base_inc = (sum_inc >= DEPTH_W) ? IDX_W'(sum_inc - DEPTH_W) : sum_inc[IDX_W-1:0];

        valid_next = valid_reg;
        base_next  = base_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else begin
            if (ctrl.write) begin
                valid_next[phys_k] = 1'b1;
            end
            if (ctrl.shift) begin
                valid_next[base_reg] = 1'b0;
                base_next            = base_inc;
            end
        end

        stat.slot_hit   = valid_reg[phys_k];
        stat.next_valid = valid_reg[base_inc];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            base_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            base_reg  <= base_next;
        end
    end

    // head read at the upcoming base, so the new head tag is ready right after a shift
    always_ff @(posedge aclk) begin
        if (ctrl.write) begin
            tag_mem[phys_k] <= wr_tag;
        end
        head_tag_reg <= tag_mem[base_next];
    end

    assign head_tag = head_tag_reg;

`ifndef SYNTHESIS
    // clear and shift never coincide: start items never walk
    a_clear_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |-> !ctrl.shift && !ctrl.write)
        else $error("store clear overlaps shift or write");
`endif

endmodule

`default_nettype wire

// ===== verif/sliding_window_receive_reorder_core_tb.sv =====
// ----------------------------------------------------------------------------
// sliding_window_receive_reorder_core_tb
// Drives start and data packets into the receive reorder core and checks every
// result word against an in-bench model of the sequence state and reorder
// store. Covers reset state, a full-depth release walk across the number wrap,
// window extremes, a long receiver hold-off, and random sessions.
// ----------------------------------------------------------------------------
module sliding_window_receive_reorder_core_tb;
    import swrr_pkg::*;

    localparam int DEPTH        = DEFAULT_WINDOW_DEPTH;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 80;

    typedef struct {
        event_t      ev;
        logic [15:0] number;
        logic [7:0]  tag;
        logic        is_last;
    } result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WIN_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;   // packet_number[15:0], packet_tag[23:16]
    logic              s_tuser;   // kind
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // out_number[15:0], out_tag[23:16]
    logic [EV_W-1:0]   m_tuser;   // event_res
    logic              m_tlast;

    // model of the receive state
    logic [15:0]       head_seq = 16'd0;      // last in-order == last delivered
    logic [WIN_W-1:0]  window_size_q = WINDOW_RESET;
    bit                held_valid [DEPTH];
    logic [7:0]        held_tag   [DEPTH];

    result_t           pending_results [$];
    int                errors      = 0;
    int                cycle_count = 0;
    bit                tx_idle     = 1'b0;
    bit                rx_idle     = 1'b0;
    bit                hold_req    = 1'b0;
    int                hold_left   = 0;
    int                rx_wait     = 0;

    sliding_window_receive_reorder_core #(
        .WINDOW_DEPTH(DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("sliding_window_receive_reorder_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic bit seq_later(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && !d[15];
    endfunction

    function automatic void queue_result(input event_t ev, input logic [15:0] num,
                                         input logic [7:0] tag);
        result_t r;
        r.ev      = ev;
        r.number  = num;
        r.tag     = tag;
        r.is_last = 1'b0;
        pending_results.push_back(r);
    endfunction

    function automatic void shift_store();
        int i;
        for (i = 0; i < DEPTH - 1; i++) begin
            held_valid[i] = held_valid[i + 1];
            held_tag[i]   = held_tag[i + 1];
        end
        held_valid[DEPTH - 1] = 1'b0;
    endfunction

    function automatic void predict_arrival(input logic kind, input logic [15:0] num,
                                            input logic [7:0] tag);
        logic [15:0]               off;
        logic [$clog2(DEPTH)-1:0]  k;
        int                        win;
        int                        n;
        int                        i;
        if (kind == KIND_START) begin
            head_seq = num;
            for (i = 0; i < DEPTH; i++) held_valid[i] = 1'b0;
            queue_result(EV_STARTED, num, tag);
        end else begin
            win = (window_size_q > DEPTH) ? DEPTH : window_size_q;
            off = num - head_seq;
            k   = $clog2(DEPTH)'(off - 16'd1);
            if (seq_later(num, head_seq + 16'(win))) begin
                queue_result(EV_DROPPED, num, tag);
            end else if (!seq_later(num, head_seq)) begin
                queue_result(EV_DUPLICATE, num, tag);
            end else if (off == 16'd1) begin
                head_seq = num;
                queue_result(EV_DELIVERED, num, tag);
                shift_store();
                n = 1;
                // release buffered successors until a hole
                while (n < DEPTH && held_valid[0]) begin
                    head_seq = head_seq + 16'd1;
                    queue_result(EV_DELIVERED, head_seq, held_tag[0]);
                    shift_store();
                    n++;
                end
            end else if (off > DEPTH) begin
                queue_result(EV_DROPPED, num, tag);
            end else if (held_valid[k]) begin
                queue_result(EV_DUPLICATE, num, tag);
            end else begin
                held_valid[k] = 1'b1;
                held_tag[k]   = tag;
                queue_result(EV_BUFFERED, num, tag);
            end
        end
        pending_results[pending_results.size() - 1].is_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result side: stalls and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req || hold_left > 0) begin
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_tready <= (rx_wait == 0);
        end else if (m_tvalid || !m_tready) begin
            // a word just went out, or ready is low: pick the next stall
            rx_wait = rx_idle ? $urandom_range(0, 6) : 0;
            m_tready <= (rx_wait == 0);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word event %0d number %0h tag %0h last %0b",
                         $time, m_tuser, m_tdata[15:0], m_tdata[23:16], m_tlast);
                errors++;
            end else begin
                r = pending_results.pop_front();
                check_field("event", 32'(r.ev), 32'(m_tuser));
                check_field("number", 32'(r.number), 32'(m_tdata[15:0]));
                check_field("tag", 32'(r.tag), 32'(m_tdata[23:16]));
                check_field("last", 32'(r.is_last), 32'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_packet(input logic kind, input logic [15:0] num,
                               input logic [7:0] tag);
        int gap;
        gap = tx_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {tag, num};
        do @(posedge aclk); while (!s_tready);
        predict_arrival(kind, num, tag);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        window_size_q = value;
        cfg_valid <= 1'b0;
    endtask

    // mostly numbers near the window, some stale ones, a few anywhere
    task automatic send_random_packet();
        int          weff;
        int          pick;
        logic [15:0] num;
        weff = (window_size_q > DEPTH) ? DEPTH : window_size_q;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            num = head_seq + 16'd1;
        else if (pick < 75)
            num = head_seq + 16'($urandom_range(2, weff + 2));
        else if (pick < 88)
            num = head_seq - 16'($urandom_range(0, 8));
        else
            num = 16'($urandom);
        send_packet((pick < 97) ? KIND_DATA : KIND_START, num, 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_packet(KIND_DATA, 16'd1, 8'h00);
        send_packet(KIND_DATA, 16'd18, 8'hFF);
    endtask

    // fill all slots across the 0xFFFF wrap, then release them in one walk
    task automatic test_full_walk();
        int          i;
        logic [15:0] base;
        base = 16'hFFF5;
        write_window(5'd31);
        send_packet(KIND_START, base, 8'hFF);
        for (i = 16; i >= 2; i--)
            send_packet(KIND_DATA, base + 16'(i), 8'(i * 17 - 17));
        send_packet(KIND_DATA, base + 16'd5, 8'hA5);
        send_packet(KIND_DATA, base + 16'd17, 8'h3C);
        send_packet(KIND_DATA, base + 16'd1, 8'h7E);
    endtask

    task automatic test_window_limits();
        write_window(5'd0);
        send_packet(KIND_START, 16'h0000, 8'h5A);
        send_packet(KIND_DATA, 16'h0001, 8'h11);
        send_packet(KIND_DATA, 16'h0000, 8'h22);
        write_window(5'd1);
        send_packet(KIND_DATA, 16'h0002, 8'h33);
        send_packet(KIND_DATA, 16'h0001, 8'h44);
    endtask

    task automatic test_backpressure();
        int i;
        write_window(5'd16);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        send_packet(KIND_START, 16'($urandom), 8'($urandom));
        for (i = 0; i < 24; i++) send_random_packet();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_sessions();
        int sent;
        int session_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_window(5'($urandom_range(0, 31)));
            else
                write_window(5'($urandom_range(2, 16)));
            send_packet(KIND_START, 16'($urandom), 8'($urandom));
            session_len = $urandom_range(8, 30);
            repeat (session_len) send_random_packet();
            sent += session_len + 1;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_START;
        m_tready  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_full_walk();
        test_window_limits();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_backpressure();
        test_random_sessions();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("sliding_window_receive_reorder_core_tb OK");
        else
            $display("sliding_window_receive_reorder_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== sliding_window_receive_reorder_core.f =====
sv/swrr_pkg.sv
sv/swrr_alu.sv
sv/swrr_store.sv
sv/sliding_window_receive_reorder_core.sv
verif/sliding_window_receive_reorder_core_tb.sv
